>>> rtl/core/bas_pkg.sv
// ============================================================================
// bas_pkg: shared types and constants for the bandit arm selector
// Arm table sizing, policy and register codes, ln table, divider interface.
// ============================================================================
package bas_pkg;

  localparam int NUM_ARMS = 16;
  localparam int ARM_W    = $clog2(NUM_ARMS);
  localparam int CNT_W    = $clog2(NUM_ARMS + 1);

  // policy codes
  localparam logic [1:0] MODE_EPS    = 2'd0;
  localparam logic [1:0] MODE_UCB    = 2'd1;
  localparam logic [1:0] MODE_ANNEAL = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_EPS    = 2'd1;
  localparam logic [1:0] REG_WEIGHT = 2'd2;
  localparam logic [1:0] REG_ARMS   = 2'd3;

  localparam logic [15:0] LN2_Q16       = 16'd45426;
  localparam logic [25:0] UNTRIED_BONUS = 26'd65536000; // 1000 in Q16.16
  localparam logic [16:0] EPS_ONE       = 17'd65536;

  // divider geometry
  localparam int DVD_W     = 33;
  localparam int DSR_W     = 32;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

  // round(65536*log2(1+k/16))
  function automatic logic [15:0] log2_frac(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd0;
      4'd1:    v = 16'd5732;
      4'd2:    v = 16'd11136;
      4'd3:    v = 16'd16248;
      4'd4:    v = 16'd21098;
      4'd5:    v = 16'd25711;
      4'd6:    v = 16'd30109;
      4'd7:    v = 16'd34312;
      4'd8:    v = 16'd38336;
      4'd9:    v = 16'd42196;
      4'd10:   v = 16'd45904;
      4'd11:   v = 16'd49472;
      4'd12:   v = 16'd52911;
      4'd13:   v = 16'd56229;
      4'd14:   v = 16'd59434;
      default: v = 16'd62534;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/bas_ram.sv
// ============================================================================
// bas_ram: generic single-port-write, single-port-read RAM
// Registered read.
// ============================================================================
module bas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bas_div.sv
// ============================================================================
// bas_div: restoring divider, one quotient bit per cycle
// Shared by the UCB bonus, annealing epsilon and the modulo picks.
// ============================================================================
module bas_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bas_pkg::div_req_t req,
  output bas_pkg::div_rsp_t rsp,
  output logic              busy
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [bas_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bas_pkg::DSR_W:0]        rem_r, rem_nxt;
  logic [bas_pkg::DVD_W-1:0]      quo_r, quo_nxt;
  logic [bas_pkg::DSR_W-1:0]      dsr_r, dsr_nxt;
  logic [bas_pkg::DSR_W:0]        trial;
  logic                           ge;

  assign trial = {rem_r[bas_pkg::DSR_W-1:0], quo_r[bas_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, dsr_r}) : trial;
      quo_nxt = {quo_r[bas_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bas_pkg::DIV_CNT_W'(bas_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy          = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[bas_pkg::DSR_W-1:0];

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider done without a running division");

endmodule

>>> rtl/core/bandit_arm_selector.sv
// ============================================================================
// bandit_arm_selector: multi-armed bandit arm choice (UCB1 / epsilon greedy)
// Arm table in RAM, a sequencer that walks the arms through one divider,
// a bit-serial square root and one multiplier.
// ============================================================================
// Load word: written to the arm table, next word taken straight after.
// Choose word, epsilon greedy: when exploring, a random % n division picks
//   the arm; else each arm is read and scored, a tie division picks among
//   the best and a search finds that tied arm; annealing first sums the
//   attempts, takes the ln and, when ln t exceeds one, divides for epsilon.
// Choose word, UCB: after the ln, each arm is set by the shared divider and
//   the 19-step square root.
// One word in flight; the result sits in an output register so the next word
//   is taken while it waits. Sync active-low reset clears control and the
//   configuration registers; the arm table is undefined until loaded.
module bandit_arm_selector (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_arm_index,
  input  logic signed [31:0] in_value_estimate,
  input  logic [31:0] in_attempt_count,
  input  logic [31:0] in_time_step,
  input  logic [15:0] in_random_decide,
  input  logic [31:0] in_random_pick,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_chosen_arm,
  output logic        out_explored,
  output logic [4:0]  out_tie_count,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = bas_pkg::ARM_W;
  localparam int CW = bas_pkg::CNT_W;

  // sequencer codes
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SUM_RD   = 5'd1;
  localparam logic [4:0] S_SUM_ACC  = 5'd2;
  localparam logic [4:0] S_LN_NORM  = 5'd3;
  localparam logic [4:0] S_LN_MUL   = 5'd4;
  localparam logic [4:0] S_EPS      = 5'd5;
  localparam logic [4:0] S_EPS_WAIT = 5'd6;
  localparam logic [4:0] S_DECIDE   = 5'd7;
  localparam logic [4:0] S_EXP_WAIT = 5'd8;
  localparam logic [4:0] S_ARM_RD   = 5'd9;
  localparam logic [4:0] S_ARM_GET  = 5'd10;
  localparam logic [4:0] S_UCB_WAIT = 5'd11;
  localparam logic [4:0] S_SQRT     = 5'd12;
  localparam logic [4:0] S_MUL      = 5'd13;
  localparam logic [4:0] S_ADD      = 5'd14;
  localparam logic [4:0] S_TIE_DIV  = 5'd15;
  localparam logic [4:0] S_TIE_WAIT = 5'd16;
  localparam logic [4:0] S_FIND     = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  mode_cfg_r;
  logic [16:0] eps_cfg_r;
  logic [15:0] weight_r;
  logic [4:0]  arms_cfg_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r <= bas_pkg::MODE_UCB;
      eps_cfg_r  <= 17'd6554;
      weight_r   <= 16'd256;
      arms_cfg_r <= 5'd16;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bas_pkg::REG_MODE:   mode_cfg_r <= pwdata[1:0];
        bas_pkg::REG_EPS:    eps_cfg_r  <= pwdata[16:0];
        bas_pkg::REG_WEIGHT: weight_r   <= pwdata[15:0];
        default:             arms_cfg_r <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bas_pkg::REG_MODE:   prdata = {30'd0, mode_cfg_r};
      bas_pkg::REG_EPS:    prdata = {15'd0, eps_cfg_r};
      bas_pkg::REG_WEIGHT: prdata = {16'd0, weight_r};
      default:             prdata = {27'd0, arms_cfg_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // arm table: {estimate, attempts}
  // --------------------------------------------------------------------------
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  bas_ram #(.WIDTH(64), .DEPTH(bas_pkg::NUM_ARMS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_arm_index[AW-1:0]),
    .wdata ({in_value_estimate, in_attempt_count}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // shared divider
  // --------------------------------------------------------------------------
  bas_pkg::div_req_t div_req;
  bas_pkg::div_rsp_t div_rsp;
  logic              div_busy;

  bas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp),
    .busy  (div_busy)
  );

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  logic [4:0]         state_r, state_nxt;
  logic               greedy_r, greedy_nxt;    // score is the bare estimate
  logic               ucb_r, ucb_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [15:0]        rdec_r, rdec_nxt;
  logic [31:0]        rnd_r, rnd_nxt;
  logic [35:0]        x_r, x_nxt;              // ln argument, normalised in place
  logic [5:0]         p_r, p_nxt;
  logic [21:0]        ln_r, ln_nxt;
  logic [16:0]        eps_r, eps_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] est_r, est_nxt;
  logic [37:0]        srem_r, srem_nxt;
  logic [37:0]        root_r, root_nxt;
  logic [37:0]        bit_r, bit_nxt;
  logic [25:0]        bonus_r, bonus_nxt;
  logic [41:0]        prod_r, prod_nxt;
  logic signed [31:0] best_r, best_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      tgt_r, tgt_nxt;
  logic signed [31:0] score_r [bas_pkg::NUM_ARMS];
  logic               score_we;
  logic signed [31:0] score_val;
  logic               out_valid_r, out_valid_nxt;
  logic [AW-1:0]      arm_r, arm_nxt;
  logic               expl_r, expl_nxt;
  logic [CW-1:0]      ties_r, ties_nxt;
  logic [AW-1:0]      out_arm_r;
  logic               out_expl_r;
  logic [CW-1:0]      out_ties_r;

  logic [CW-1:0]      n_clamp;
  logic [21:0]        l2;
  logic [37:0]        ln_prod;
  logic [37:0]        trial;
  logic signed [35:0] sum36;
  logic               last_arm;

  always_comb begin
    if (arms_cfg_r == '0) begin
      n_clamp = CW'(1);
    end else if (arms_cfg_r > 5'(bas_pkg::NUM_ARMS)) begin
      n_clamp = CW'(bas_pkg::NUM_ARMS);
    end else begin
      n_clamp = arms_cfg_r[CW-1:0];
    end
  end

  assign l2       = {p_r, 16'd0} + {6'd0, bas_pkg::log2_frac(x_r[34:31])};
  assign ln_prod  = l2 * bas_pkg::LN2_Q16;
  assign trial    = root_r + bit_r;
  assign sum36    = 36'(est_r) + {2'b00, prod_r[41:8]};
  assign last_arm = (idx_r + 1'b1) == n_r;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_chosen_arm = out_arm_r;
  assign out_explored   = out_expl_r;
  assign out_tie_count  = out_ties_r;

  always_comb begin
    state_nxt  = state_r;
    greedy_nxt = greedy_r;
    ucb_nxt    = ucb_r;
    n_nxt      = n_r;
    rdec_nxt   = rdec_r;
    rnd_nxt    = rnd_r;
    x_nxt      = x_r;
    p_nxt      = p_r;
    ln_nxt     = ln_r;
    eps_nxt    = eps_r;
    idx_nxt    = idx_r;
    est_nxt    = est_r;
    srem_nxt   = srem_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    bonus_nxt  = bonus_r;
    prod_nxt   = prod_r;
    best_nxt   = best_r;
    cnt_nxt    = cnt_r;
    tgt_nxt    = tgt_r;
    arm_nxt    = arm_r;
    expl_nxt   = expl_r;
    ties_nxt   = ties_r;
    score_we   = 1'b0;
    score_val  = est_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    div_req    = '0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_action) begin
            ram_we = 1'b1;
          end else begin
            n_nxt    = n_clamp;
            rdec_nxt = in_random_decide;
            rnd_nxt  = in_random_pick;
            idx_nxt  = '0;
            p_nxt    = 6'd35;
            if (mode_cfg_r == bas_pkg::MODE_EPS) begin
              greedy_nxt = 1'b1;
              ucb_nxt    = 1'b0;
              eps_nxt    = eps_cfg_r;
              state_nxt  = S_DECIDE;
            end else if (mode_cfg_r == bas_pkg::MODE_ANNEAL) begin
              greedy_nxt = 1'b1;
              ucb_nxt    = 1'b0;
              x_nxt      = 36'd1;
              state_nxt  = S_SUM_RD;
            end else begin
              greedy_nxt = 1'b0;
              ucb_nxt    = 1'b1;
              x_nxt      = 36'(in_time_step) + 36'd1;
              state_nxt  = S_LN_NORM;
            end
          end
        end
      end
      // annealing: t = 1 + sum of attempts over the arms in use
      S_SUM_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        x_nxt   = x_r + 36'(ram_rdata[31:0]);
        idx_nxt = idx_r + 1'b1;
        state_nxt = last_arm ? S_LN_NORM : S_SUM_RD;
      end
      // leading one search, one bit a cycle
      S_LN_NORM: begin
        if (x_r[35] || x_r == '0) begin
          state_nxt = S_LN_MUL;
        end else begin
          x_nxt = {x_r[34:0], 1'b0};
          p_nxt = p_r - 1'b1;
        end
      end
      S_LN_MUL: begin
        ln_nxt  = (x_r == '0) ? 22'd0 : ln_prod[37:16];
        idx_nxt = '0;
        cnt_nxt = '0;
        state_nxt = ucb_r ? S_ARM_RD : S_EPS;
      end
      // annealing epsilon = min(1, 1/ln t)
      S_EPS: begin
        if (ln_r <= 22'd65536) begin
          eps_nxt   = bas_pkg::EPS_ONE;
          state_nxt = S_DECIDE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 33'h1_0000_0000;
          div_req.divisor  = 32'(ln_r);
          state_nxt        = S_EPS_WAIT;
        end
      end
      S_EPS_WAIT: begin
        if (div_rsp.done) begin
          eps_nxt   = div_rsp.quotient[16:0];
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_nxt = '0;
        cnt_nxt = '0;
        if ({1'b0, rdec_r} < eps_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = 33'(rnd_r);
          div_req.divisor  = 32'(n_r);
          state_nxt        = S_EXP_WAIT;
        end else begin
          state_nxt = S_ARM_RD;
        end
      end
      S_EXP_WAIT: begin
        if (div_rsp.done) begin
          arm_nxt   = div_rsp.remainder[AW-1:0];
          expl_nxt  = 1'b1;
          ties_nxt  = CW'(1);
          state_nxt = S_DONE;
        end
      end
      // per-arm score walk
      S_ARM_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_ARM_GET;
      end
      S_ARM_GET: begin
        est_nxt = ram_rdata[63:32];
        if (greedy_r) begin
          prod_nxt  = '0;
          state_nxt = S_ADD;
        end else if (ram_rdata[31:0] == '0) begin
          bonus_nxt = bas_pkg::UNTRIED_BONUS;
          state_nxt = S_MUL;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 33'(ln_r);
          div_req.divisor  = ram_rdata[31:0];
          state_nxt        = S_UCB_WAIT;
        end
      end
      S_UCB_WAIT: begin
        if (div_rsp.done) begin
          srem_nxt  = {div_rsp.quotient[21:0], 16'd0};
          root_nxt  = '0;
          bit_nxt   = 38'd1 << 36;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (srem_r >= trial) begin
          srem_nxt = srem_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 38'd1) begin
          bonus_nxt = root_nxt[25:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = bonus_r * weight_r;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (sum36 > 36'sd2147483647) begin
          score_val = 32'sh7FFF_FFFF;
        end else begin
          score_val = sum36[31:0];
        end
        score_we = 1'b1;
        if (cnt_r == '0 || score_val > best_r) begin
          best_nxt = score_val;
          cnt_nxt  = CW'(1);
        end else if (score_val == best_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = last_arm ? S_TIE_DIV : S_ARM_RD;
      end
      // tie pick: random % ties, then find that tied arm in index order
      S_TIE_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 33'(rnd_r);
        div_req.divisor  = 32'(cnt_r);
        state_nxt        = S_TIE_WAIT;
      end
      S_TIE_WAIT: begin
        if (div_rsp.done) begin
          tgt_nxt   = div_rsp.remainder[CW-1:0];
          idx_nxt   = '0;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (score_r[idx_r[AW-1:0]] == best_r) begin
          if (tgt_r == '0) begin
            arm_nxt   = idx_r[AW-1:0];
            expl_nxt  = 1'b0;
            ties_nxt  = cnt_r;
            state_nxt = S_DONE;
          end else begin
            tgt_nxt = tgt_r - 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    greedy_r <= greedy_nxt;
    ucb_r    <= ucb_nxt;
    n_r      <= n_nxt;
    rdec_r   <= rdec_nxt;
    rnd_r    <= rnd_nxt;
    x_r      <= x_nxt;
    p_r      <= p_nxt;
    ln_r     <= ln_nxt;
    eps_r    <= eps_nxt;
    idx_r    <= idx_nxt;
    est_r    <= est_nxt;
    srem_r   <= srem_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    bonus_r  <= bonus_nxt;
    prod_r   <= prod_nxt;
    best_r   <= best_nxt;
    cnt_r    <= cnt_nxt;
    tgt_r    <= tgt_nxt;
    arm_r    <= arm_nxt;
    expl_r   <= expl_nxt;
    ties_r   <= ties_nxt;
    if (score_we) begin
      score_r[idx_r[AW-1:0]] <= score_val;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_arm_r  <= arm_r;
      out_expl_r <= expl_r;
      out_ties_r <= ties_r;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  property p_result_from_done;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(state_r == S_DONE);
  endproperty
  a_result_from_done: assert property (p_result_from_done)
    else $error("result word raised outside the done step");

  property p_ties_nonzero;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r |-> out_ties_r != '0;
  endproperty
  a_ties_nonzero: assert property (p_ties_nonzero)
    else $error("result word with zero tie count");

  property p_explore_single;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_expl_r) |-> out_ties_r == CW'(1);
  endproperty
  a_explore_single: assert property (p_explore_single)
    else $error("explored word with tie count other than one");

  property p_div_idle_on_start;
    @(posedge clk) disable iff (!rst_n)
      div_req.start |-> !div_busy;
  endproperty
  a_div_idle_on_start: assert property (p_div_idle_on_start)
    else $error("division issued while divider busy");

endmodule
